FILE: design/tpsr_pkg.sv
// shared types and constants for the trail point spline resampler
// no dependencies; used by every module in this folder
`timescale 1ns / 1ps

package tpsr_pkg;

  localparam int NUM_POINTS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int COORD_W        = 32;
  localparam int INDEX_W        = 5;
  localparam int DIV_STEPS      = 3;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_PUSH = 2'd1,
    OP_EVAL = 2'd2
  } op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    op_t    op;
    point_t lo;
    point_t up;
  } cmd_t;

  typedef struct packed {
    logic   valid;
    logic   push;
    point_t lo;
    point_t up;
  } store_wr_t;

  typedef enum logic [2:0] {
    EV_IDLE,
    EV_WGT,
    EV_MAC,
    EV_PREP,
    EV_DIV,
    EV_EMIT
  } eval_state_t;

endpackage

FILE: design/tpsr_front.sv
// front end: accepts requests, drops unused opcodes, queues commands
// depends on tpsr_pkg
`timescale 1ns / 1ps

module tpsr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpsr_pkg::cmd_t    in_cmd,
  input  logic [1:0]        in_code,
  output logic              q_valid,
  output tpsr_pkg::cmd_t    q_head,
  input  logic              q_pop
);

  localparam int PW = (tpsr_pkg::QUEUE_DEPTH > 1) ? $clog2(tpsr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(tpsr_pkg::QUEUE_DEPTH + 1);

  tpsr_pkg::cmd_t queue [tpsr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           known;
  logic           push_q;
  logic           pop_q;

  assign in_ready = (count < CW'(tpsr_pkg::QUEUE_DEPTH));
  assign known    = (in_code == tpsr_pkg::OP_INIT) || (in_code == tpsr_pkg::OP_PUSH) ||
                    (in_code == tpsr_pkg::OP_EVAL);
  assign push_q   = in_valid && in_ready && known;
  assign pop_q    = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_head   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_q) begin
      queue[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_q) begin
        wr_ptr <= (wr_ptr == PW'(tpsr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_q) begin
        rd_ptr <= (rd_ptr == PW'(tpsr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_q && !pop_q) begin
        count <= count + 1'b1;
      end else if (pop_q && !push_q) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(tpsr_pkg::QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_drop_unknown: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !known && !pop_q) |=> (count == $past(count)))
    else $error("unused opcode reached the queue");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(tpsr_pkg::QUEUE_DEPTH)) |-> !in_ready)
    else $error("ready while queue full");

endmodule

FILE: design/tpsr_store.sv
// point store: shift line of lower/upper pairs with fixed control taps
// depends on tpsr_pkg
`timescale 1ns / 1ps

module tpsr_store #(
  parameter int NUM_POINTS = tpsr_pkg::NUM_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tpsr_pkg::store_wr_t wr,
  output tpsr_pkg::point_t    ctrl_lo [4],
  output tpsr_pkg::point_t    ctrl_up [4]
);

  localparam int Q   = NUM_POINTS / 4;
  localparam int R   = (3 * NUM_POINTS) / 4;
  localparam int LS1 = (Q % 2 != 0) ? Q + 1 : Q;
  localparam int LS2 = (R % 2 != 0) ? R - 1 : R;
  localparam int US1 = (Q % 2 == 0) ? Q + 1 : Q;
  localparam int US2 = (R % 2 == 0) ? R - 1 : R;

  tpsr_pkg::point_t slots [NUM_POINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_POINTS; s++) begin
        slots[s] <= '0;
      end
    end else if (wr.valid) begin
      if (!wr.push) begin
        for (int s = 0; s < NUM_POINTS; s++) begin
          slots[s] <= (s % 2 == 0) ? wr.lo : wr.up;
        end
      end else begin
        for (int s = 0; s < NUM_POINTS - 2; s++) begin
          slots[s] <= slots[s+2];
        end
        slots[NUM_POINTS-2] <= wr.lo;
        slots[NUM_POINTS-1] <= wr.up;
      end
    end
  end

  assign ctrl_lo[0] = slots[0];
  assign ctrl_lo[1] = slots[LS1];
  assign ctrl_lo[2] = slots[LS2];
  assign ctrl_lo[3] = slots[NUM_POINTS-2];
  assign ctrl_up[0] = slots[1];
  assign ctrl_up[1] = slots[US1];
  assign ctrl_up[2] = slots[US2];
  assign ctrl_up[3] = slots[NUM_POINTS-1];

endmodule

FILE: design/tpsr_eval.sv
// back end: runs queued commands, spline weights, multiply-accumulate,
// rounding divider and output register; depends on tpsr_pkg
`timescale 1ns / 1ps

module tpsr_eval #(
  parameter int NUM_POINTS = tpsr_pkg::NUM_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tpsr_pkg::cmd_t                q_head,
  output logic                          q_pop,
  output tpsr_pkg::store_wr_t           store_wr,
  input  tpsr_pkg::point_t              ctrl_lo [4],
  input  tpsr_pkg::point_t              ctrl_up [4],
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpsr_pkg::INDEX_W-1:0]  vertex_index,
  output logic signed [tpsr_pkg::COORD_W-1:0] pos_x,
  output logic signed [tpsr_pkg::COORD_W-1:0] pos_y,
  output logic signed [tpsr_pkg::COORD_W-1:0] pos_z,
  output logic                          last_vertex
);

  localparam longint N3   = longint'(NUM_POINTS) * NUM_POINTS * NUM_POINTS;
  localparam longint DEN  = 2 * N3;
  localparam int     DW   = $clog2(DEN + 1);
  localparam int     WW   = $clog2(DEN) + 2;
  localparam int     ACCW = DW + 34;
  localparam int     PW   = WW + tpsr_pkg::COORD_W;
  localparam int     IW   = $clog2(NUM_POINTS);
  localparam int     SW   = $clog2(tpsr_pkg::DIV_STEPS);
  localparam int     CW   = tpsr_pkg::COORD_W;
  localparam int     RW   = DW + 3;
  localparam logic signed [ACCW-1:0] ROUND_OFS  = ACCW'(N3);
  localparam logic signed [ACCW-1:0] HALF_RANGE = ACCW'(DEN) <<< 31;
  localparam logic signed [ACCW-1:0] FULL_RANGE = ACCW'(DEN) <<< 32;
  localparam logic [31:0]            DEN_U      = 32'(DEN);
  localparam logic [31:0]            RECIP      = 32'((longint'(1) <<< (DW + 30)) / DEN);
  localparam logic [IW-1:0]          LAST_I     = IW'(NUM_POINTS - 1);
  localparam logic [31:0]            LAST_IDX   = 32'(NUM_POINTS - 1);
  localparam logic signed [31:0]     NS         = 32'(NUM_POINTS);
  localparam logic signed [31:0]     N3S        = 32'(N3);

  tpsr_pkg::eval_state_t state, state_next;

  logic [IW-1:0]          i;
  logic [2:0]             j;
  logic [SW-1:0]          step;
  logic signed [WW-1:0]   w [4];
  logic signed [WW-1:0]   w_calc [4];
  logic signed [PW-1:0]   prod [3];
  logic signed [ACCW-1:0] acc [3];
  logic [CW-1:0]          uh [3];
  logic [RW-1:0]          ul [3];
  logic [CW-1:0]          qe [3];
  logic [RW-1:0]          rr [3];
  logic [63:0]            qe_prod [3];
  logic [63:0]            qd_prod [3];
  logic [2:0]             corr [3];
  logic [CW-1:0]          quo [3];
  logic                   sat_hi [3];
  logic                   sat_lo [3];
  logic signed [CW-1:0]   res [3];
  logic                   load;
  tpsr_pkg::point_t       sel_pt;
  logic signed [CW-1:0]   sel_c [3];
  logic signed [31:0]     ti, tt, ttt;

  // weights of the uniform curve for the current vertex
  always_comb begin
    ti  = 32'(i);
    tt  = ti * ti;
    ttt = tt * ti;
    w_calc[0] = WW'(-ttt + 2 * tt * NS - ti * NS * NS);
    w_calc[1] = WW'(3 * ttt - 5 * tt * NS + 2 * N3S);
    w_calc[2] = WW'(-3 * ttt + 4 * tt * NS + ti * NS * NS);
    w_calc[3] = WW'(ttt - tt * NS);
  end

  always_comb begin
    sel_pt   = i[0] ? ctrl_up[j[1:0]] : ctrl_lo[j[1:0]];
    sel_c[0] = sel_pt.x;
    sel_c[1] = sel_pt.y;
    sel_c[2] = sel_pt.z;
  end

  // reciprocal estimate falls short by at most six, then fixed up
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qe_prod[c] = 64'(uh[c]) * 64'(RECIP);
      qd_prod[c] = 64'(qe[c]) * 64'(DEN_U);
      corr[c]    = '0;
      for (int k = 1; k <= 6; k++) begin
        if (rr[c] >= RW'(longint'(k) * DEN)) begin
          corr[c] = corr[c] + 3'd1;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (sat_hi[c]) begin
        res[c] = {1'b0, {(CW-1){1'b1}}};
      end else if (sat_lo[c]) begin
        res[c] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        res[c] = {~quo[c][CW-1], quo[c][CW-2:0]};
      end
    end
  end

  assign load = (state == tpsr_pkg::EV_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      tpsr_pkg::EV_IDLE: begin
        if (q_valid && (q_head.op == tpsr_pkg::OP_EVAL)) begin
          state_next = tpsr_pkg::EV_WGT;
        end
      end
      tpsr_pkg::EV_WGT: state_next = tpsr_pkg::EV_MAC;
      tpsr_pkg::EV_MAC: begin
        if (j == 3'd4) begin
          state_next = tpsr_pkg::EV_PREP;
        end
      end
      tpsr_pkg::EV_PREP: state_next = tpsr_pkg::EV_DIV;
      tpsr_pkg::EV_DIV: begin
        if (step == SW'(tpsr_pkg::DIV_STEPS - 1)) begin
          state_next = tpsr_pkg::EV_EMIT;
        end
      end
      tpsr_pkg::EV_EMIT: begin
        if (load) begin
          state_next = (i == LAST_I) ? tpsr_pkg::EV_IDLE : tpsr_pkg::EV_WGT;
        end
      end
      default: state_next = tpsr_pkg::EV_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = (state == tpsr_pkg::EV_IDLE) && q_valid;
    store_wr.valid = q_pop && (q_head.op != tpsr_pkg::OP_EVAL);
    store_wr.push  = (q_head.op == tpsr_pkg::OP_PUSH);
    store_wr.lo    = q_head.lo;
    store_wr.up    = q_head.up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpsr_pkg::EV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tpsr_pkg::EV_IDLE: begin
        i <= '0;
      end
      tpsr_pkg::EV_WGT: begin
        w <= w_calc;
        j <= '0;
        for (int c = 0; c < 3; c++) begin
          acc[c] <= ROUND_OFS;
        end
      end
      tpsr_pkg::EV_MAC: begin
        j <= j + 1'b1;
        for (int c = 0; c < 3; c++) begin
          if (j != 3'd4) begin
            prod[c] <= PW'(w[j[1:0]]) * PW'(sel_c[c]);
          end
          if (j != 3'd0) begin
            acc[c] <= acc[c] + ACCW'(prod[c]);
          end
        end
      end
      tpsr_pkg::EV_PREP: begin
        step <= '0;
        for (int c = 0; c < 3; c++) begin
          sat_hi[c] <= (acc[c] + HALF_RANGE) >= FULL_RANGE;
          sat_lo[c] <= (acc[c] + HALF_RANGE) < 0;
          uh[c]     <= CW'((acc[c] + HALF_RANGE) >>> DW);
          ul[c]     <= RW'(acc[c] + HALF_RANGE);
        end
      end
      tpsr_pkg::EV_DIV: begin
        step <= step + 1'b1;
        for (int c = 0; c < 3; c++) begin
          if (step == SW'(0)) begin
            qe[c] <= qe_prod[c][CW+29:30];
          end else if (step == SW'(1)) begin
            rr[c] <= ul[c] - qd_prod[c][RW-1:0];
          end else begin
            quo[c] <= qe[c] + CW'(corr[c]);
          end
        end
      end
      tpsr_pkg::EV_EMIT: begin
        if (load) begin
          i <= i + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vertex_index <= tpsr_pkg::INDEX_W'(32'(i));
      pos_x        <= res[0];
      pos_y        <= res[1];
      pos_z        <= res[2];
      last_vertex  <= (i == LAST_I);
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == tpsr_pkg::EV_IDLE))
    else $error("queue popped mid evaluation");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && (i == LAST_I)) |=> (state == tpsr_pkg::EV_IDLE))
    else $error("run did not end after last vertex");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_vertex) |-> (vertex_index == LAST_IDX[tpsr_pkg::INDEX_W-1:0]))
    else $error("last vertex flag on wrong index");

endmodule

FILE: design/trail_point_spline_resampler.sv
// An evaluate request emits NUM_POINTS vertices one after another: each
// goes through weights, multiply-accumulate, range check, a reciprocal
// divide for the 2*N^3 rounding divide and output, and the next vertex
// starts only once the last is loaded, which waits while the output is
// held back; init and push are written to the store from the idle state.
// A two-entry command queue lets requests be accepted while a run is busy.
// Depends on tpsr_pkg, tpsr_front, tpsr_store, tpsr_eval.
`timescale 1ns / 1ps

module trail_point_spline_resampler #(
  parameter int NUM_POINTS = tpsr_pkg::NUM_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          opcode,
  input  logic signed [tpsr_pkg::COORD_W-1:0] lower_x,
  input  logic signed [tpsr_pkg::COORD_W-1:0] lower_y,
  input  logic signed [tpsr_pkg::COORD_W-1:0] lower_z,
  input  logic signed [tpsr_pkg::COORD_W-1:0] upper_x,
  input  logic signed [tpsr_pkg::COORD_W-1:0] upper_y,
  input  logic signed [tpsr_pkg::COORD_W-1:0] upper_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tpsr_pkg::INDEX_W-1:0]        vertex_index,
  output logic signed [tpsr_pkg::COORD_W-1:0] pos_x,
  output logic signed [tpsr_pkg::COORD_W-1:0] pos_y,
  output logic signed [tpsr_pkg::COORD_W-1:0] pos_z,
  output logic                                last_vertex
);

  tpsr_pkg::cmd_t      in_cmd;
  tpsr_pkg::cmd_t      q_head;
  logic                q_valid;
  logic                q_pop;
  tpsr_pkg::store_wr_t store_wr;
  tpsr_pkg::point_t    ctrl_lo [4];
  tpsr_pkg::point_t    ctrl_up [4];

  assign in_cmd.op   = tpsr_pkg::op_t'(opcode);
  assign in_cmd.lo.x = lower_x;
  assign in_cmd.lo.y = lower_y;
  assign in_cmd.lo.z = lower_z;
  assign in_cmd.up.x = upper_x;
  assign in_cmd.up.y = upper_y;
  assign in_cmd.up.z = upper_z;

  tpsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_code  (opcode),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  tpsr_store #(.NUM_POINTS(NUM_POINTS)) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (store_wr),
    .ctrl_lo (ctrl_lo),
    .ctrl_up (ctrl_up)
  );

  tpsr_eval #(.NUM_POINTS(NUM_POINTS)) u_eval (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .store_wr     (store_wr),
    .ctrl_lo      (ctrl_lo),
    .ctrl_up      (ctrl_up),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .last_vertex  (last_vertex)
  );

endmodule

FILE: tb/trail_point_spline_resampler_tb.sv
// testbench for the trail point spline resampler: directed and random requests,
// a built-in Catmull-Rom predictor and an in-order vertex checker
// depends on tpsr_pkg and trail_point_spline_resampler
`timescale 1ns / 1ps

module trail_point_spline_resampler_tb;

  localparam int NPTS = tpsr_pkg::NUM_POINTS_DEF;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef logic signed [tpsr_pkg::COORD_W-1:0] coord_t;

  typedef struct {
    logic [tpsr_pkg::INDEX_W-1:0] idx;
    coord_t                       x;
    coord_t                       y;
    coord_t                       z;
    logic                         last;
  } vertex_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] opcode = '0;
  coord_t lower_x = '0, lower_y = '0, lower_z = '0;
  coord_t upper_x = '0, upper_y = '0, upper_z = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [tpsr_pkg::INDEX_W-1:0] vertex_index;
  coord_t pos_x, pos_y, pos_z;
  logic last_vertex;

  coord_t trail [NPTS][3];
  vertex_t pending_vertices[$];
  int  errors = 0;
  bit  calm = 0;

  trail_point_spline_resampler dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
    .lower_x(lower_x), .lower_y(lower_y), .lower_z(lower_z),
    .upper_x(upper_x), .upper_y(upper_y), .upper_z(upper_z),
    .out_valid(out_valid), .out_ready(out_ready), .vertex_index(vertex_index),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last_vertex(last_vertex)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic coord_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // predictor for one accepted request
  function automatic void apply_request(logic [1:0] op, coord_t lo[3], coord_t up[3]);
    int q, r, i, k, c;
    int lsl[4], usl[4], sl[4];
    longint n, n3, t, acc;
    longint w[4];
    vertex_t v;
    coord_t res[3];
    n = NPTS;
    n3 = n * n * n;
    q = NPTS / 4;
    r = (3 * NPTS) / 4;
    case (op)
      tpsr_pkg::OP_INIT: begin
        for (i = 0; i < NPTS; i++)
          for (c = 0; c < 3; c++) trail[i][c] = (i % 2 == 0) ? lo[c] : up[c];
      end
      tpsr_pkg::OP_PUSH: begin
        for (i = 0; i < NPTS - 2; i++) trail[i] = trail[i + 2];
        trail[NPTS - 2] = lo;
        trail[NPTS - 1] = up;
      end
      tpsr_pkg::OP_EVAL: begin
        lsl = '{0, (q % 2 != 0) ? q + 1 : q, (r % 2 != 0) ? r - 1 : r, NPTS - 2};
        usl = '{1, (q % 2 == 0) ? q + 1 : q, (r % 2 == 0) ? r - 1 : r, NPTS - 1};
        for (i = 0; i < NPTS; i++) begin
          t = i;
          if (i % 2 == 0) sl = lsl;
          else sl = usl;
          w[0] = -t * t * t + 2 * t * t * n - t * n * n;
          w[1] = 3 * t * t * t - 5 * t * t * n + 2 * n3;
          w[2] = -3 * t * t * t + 4 * t * t * n + t * n * n;
          w[3] = t * t * t - t * t * n;
          for (c = 0; c < 3; c++) begin
            acc = 0;
            for (k = 0; k < 4; k++) acc += w[k] * longint'(trail[sl[k]][c]);
            res[c] = clamp32(floor_div(acc + n3, 2 * n3));
          end
          v.idx = i[tpsr_pkg::INDEX_W-1:0];
          v.x = res[0];
          v.y = res[1];
          v.z = res[2];
          v.last = (i == NPTS - 1);
          pending_vertices.push_back(v);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(logic [1:0] op, coord_t lo[3], coord_t up[3]);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    opcode <= op;
    lower_x <= lo[0]; lower_y <= lo[1]; lower_z <= lo[2];
    upper_x <= up[0]; upper_y <= up[1]; upper_z <= up[2];
    do @(posedge clk); while (!in_ready);
    apply_request(op, lo, up);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(logic [1:0] op);
    coord_t lo[3], up[3];
    for (int c = 0; c < 3; c++) begin
      lo[c] = pick_coord();
      up[c] = pick_coord();
    end
    send_request(op, lo, up);
  endtask

  task automatic test_reset_state();
    send_random(tpsr_pkg::OP_EVAL);
  endtask

  task automatic test_init_extremes();
    send_request(tpsr_pkg::OP_INIT, '{32'sh7fffffff, 32'sh80000000, 0},
                 '{32'sh80000000, 32'sh7fffffff, -1});
    send_random(tpsr_pkg::OP_EVAL);
    send_request(tpsr_pkg::OP_INIT, '{32'sh80000000, 32'sh80000000, 32'sh80000000},
                 '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    send_random(tpsr_pkg::OP_EVAL);
  endtask

  task automatic test_push_shift();
    send_request(tpsr_pkg::OP_INIT, '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
                 '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    // minimum values pushed against a saturated store overshoot the range
    repeat (6) send_request(tpsr_pkg::OP_PUSH,
                            '{32'sh80000000, 32'sh80000000, 32'sh80000000},
                            '{32'sh80000000, 32'sh80000000, 32'sh80000000});
    send_random(tpsr_pkg::OP_EVAL);
    for (int i = 0; i < 4; i++)
      send_request(tpsr_pkg::OP_PUSH, '{i << 16, -(i << 16), 32'sh00008000},
                   '{-(i << 16), i << 16, 32'shffff8000});
    send_random(tpsr_pkg::OP_EVAL);
  endtask

  task automatic test_spare_opcode();
    send_random(OP_SPARE);
    send_random(OP_SPARE);
    send_random(tpsr_pkg::OP_EVAL);
  endtask

  task automatic test_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) send_random(tpsr_pkg::OP_PUSH);
      else if (sel < 78) send_random(tpsr_pkg::OP_EVAL);
      else if (sel < 92) send_random(tpsr_pkg::OP_INIT);
      else send_random(OP_SPARE);
    end
  endtask

  task automatic test_calm_tail();
    calm = 1;
    test_random(30);
    send_random(tpsr_pkg::OP_EVAL);
  endtask

  // output back-pressure in bursts
  initial begin
    int n;
    @(negedge rst);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 12);
        out_ready <= 0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    vertex_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex index %0d", vertex_index);
        errors++;
      end else begin
        e = pending_vertices.pop_front();
        if (vertex_index !== e.idx) begin
          $error("vertex_index exp %0d got %0d", e.idx, vertex_index); errors++;
        end
        if (pos_x !== e.x) begin
          $error("pos_x exp %0d got %0d", e.x, pos_x); errors++;
        end
        if (pos_y !== e.y) begin
          $error("pos_y exp %0d got %0d", e.y, pos_y); errors++;
        end
        if (pos_z !== e.z) begin
          $error("pos_z exp %0d got %0d", e.z, pos_z); errors++;
        end
        if (last_vertex !== e.last) begin
          $error("last_vertex exp %0d got %0d", e.last, last_vertex); errors++;
        end
      end
    end
  end

  initial begin
    for (int s = 0; s < NPTS; s++) trail[s] = '{0, 0, 0};
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_reset_state();
    test_init_extremes();
    test_push_shift();
    test_spare_opcode();
    test_random(320);
    test_calm_tail();
    in_valid <= 0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/tpsr_pkg.sv
design/tpsr_front.sv
design/tpsr_store.sv
design/tpsr_eval.sv
design/trail_point_spline_resampler.sv
tb/trail_point_spline_resampler_tb.sv
